[hw/rtl/sliding_window_average_macros.svh]
// Assertion macros for the sliding window average block.
// Used by the top level; relies on clk and arst_n in the including scope.
`ifndef SLIDING_WINDOW_AVERAGE_MACROS_SVH
`define SLIDING_WINDOW_AVERAGE_MACROS_SVH
`ifndef SYNTH
`define SWA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swa assertion failed");
`define SWA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swa assertion failed");
`else
`define SWA_ASSERT_SAME(lbl, ante, cons)
`define SWA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/swa_pkg.sv]
// Package for the sliding window average block: widths and sequencer states.
// No dependencies.
`default_nettype none
package swa_pkg;
	localparam int SAMPLE_W  = 32;
	localparam int SUM_W     = 40;
	localparam int DIV_CNT_W = $clog2(SUM_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SUM,
		ST_ABS,
		ST_DIV,
		ST_DONE
	} swa_state_t;
endpackage
`default_nettype wire

[hw/rtl/sliding_window_average.sv]
// Moving average over the last WINDOW_LENGTH signed 32-bit samples.
// Depends on swa_pkg and sliding_window_average_macros.svh.
//
// Usage:
//   s_axis carries one sample per word (tdata). m_axis returns one word per
//   sample: tdata is the average, tuser is set once the window has filled.
//   Until the window fills, the sum is divided by the samples seen so far.
//   After acceptance the block steps through the difference, sum, absolute
//   value, divide and done states; s_axis_tready is high only while the
//   block is idle. The pace is set by the restoring divider, which takes
//   one quotient bit per cycle over the 40-bit sum.
//   A finished result sits in the output register; a new sample is accepted
//   while it waits. If m_axis_tready stays low, the next result holds in
//   the final step until the output register frees up, stalling the input.
//   Reset (arst_n low, asynchronous) empties the window, clears the sum,
//   the write position and the full flag, and drops m_axis_tvalid.
//   No clearing pass: slots not yet written are taken as zero until the window
//   has wrapped once.
`default_nettype none
`include "sliding_window_average_macros.svh"
module sliding_window_average #(
	parameter int WINDOW_LENGTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] sample
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata,  // [31:0] average
	output logic             m_axis_tuser   // [0] window_full
);
	localparam int PW = $clog2(WINDOW_LENGTH);
	localparam int CW = $clog2(WINDOW_LENGTH + 1);
	localparam int SW = swa_pkg::SAMPLE_W;
	localparam int AW = swa_pkg::SUM_W;
	localparam int DW = swa_pkg::DIV_CNT_W;

	swa_pkg::swa_state_t state_q, state_d;

	logic [SW-1:0] ring [WINDOW_LENGTH];
	logic [SW-1:0] old_q;
	logic [SW-1:0] sample_q;
	logic          old_vld_q;
	logic [PW-1:0] pos_q;
	logic          filled_q;
	logic [CW-1:0] divisor_q;
	logic [AW-1:0] sum_q;
	logic [SW:0]   diff_q;
	logic [AW-1:0] dividend_q;
	logic [CW-1:0] rem_q;
	logic          neg_q;
	logic [DW-1:0] cnt_q;
	logic          out_valid_q;
	logic [SW-1:0] out_avg_q;
	logic          out_full_q;

	logic          accept;
	logic          load_out;
	logic [CW-1:0] pos_inc;
	logic          wrap;
	logic [CW:0]   rem_sh;
	logic          ge;
	logic [CW:0]   rem_sub;
	logic [SW-1:0] quot;
	logic          div_last;

	assign accept  = s_axis_tvalid && s_axis_tready;
	assign pos_inc = CW'(pos_q) + CW'(1);
	assign wrap    = pos_inc == CW'(WINDOW_LENGTH);

	// one quotient bit per cycle
	assign rem_sh   = {rem_q, dividend_q[AW-1]};
	assign ge       = rem_sh >= {1'b0, divisor_q};
	assign rem_sub  = rem_sh - {1'b0, divisor_q};
	assign div_last = cnt_q == DW'(AW - 1);
	assign quot     = dividend_q[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			swa_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = swa_pkg::ST_DIFF;
				end
			end
			swa_pkg::ST_DIFF: state_d = swa_pkg::ST_SUM;
			swa_pkg::ST_SUM:  state_d = swa_pkg::ST_ABS;
			swa_pkg::ST_ABS:  state_d = swa_pkg::ST_DIV;
			swa_pkg::ST_DIV: begin
				if (div_last) begin
					state_d = swa_pkg::ST_DONE;
				end
			end
			swa_pkg::ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = swa_pkg::ST_IDLE;
				end
			end
			default: state_d = swa_pkg::ST_IDLE;
		endcase
	end

	// sample ring: read old entry and write new one at the same edge
	always_ff @(posedge clk) begin
		if (accept) begin
			ring[pos_q] <= s_axis_tdata;
			old_q       <= ring[pos_q];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			filled_q    <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pos_q <= wrap ? '0 : pos_inc[PW-1:0];
				if (wrap) begin
					filled_q <= 1'b1;
				end
			end
			if (state_q == swa_pkg::ST_SUM) begin
				sum_q <= sum_q + {{(AW-SW-1){diff_q[SW]}}, diff_q};
			end
			if (state_q == swa_pkg::ST_DIV) begin
				cnt_q <= cnt_q + DW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q  <= s_axis_tdata;
			old_vld_q <= filled_q;
			divisor_q <= (filled_q || wrap) ? CW'(WINDOW_LENGTH) : pos_inc;
		end
		if (state_q == swa_pkg::ST_DIFF) begin
			diff_q <= {sample_q[SW-1], sample_q}
				- (old_vld_q ? {old_q[SW-1], old_q} : '0);
		end
		if (state_q == swa_pkg::ST_ABS) begin
			neg_q      <= sum_q[AW-1];
			dividend_q <= sum_q[AW-1] ? (~sum_q + AW'(1)) : sum_q;
			rem_q      <= '0;
		end
		if (state_q == swa_pkg::ST_DIV) begin
			dividend_q <= {dividend_q[AW-2:0], ge};
			rem_q      <= ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
		end
		if (load_out) begin
			out_avg_q  <= neg_q ? (~quot + SW'(1)) : quot;
			out_full_q <= filled_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_avg_q;
	assign m_axis_tuser  = out_full_q;

	`SWA_ASSERT_NEXT(a_accept_starts, accept, state_q == swa_pkg::ST_DIFF)
	`SWA_ASSERT_SAME(a_div_nonzero, state_q == swa_pkg::ST_DIV, divisor_q != '0)
	`SWA_ASSERT_SAME(a_rem_below, state_q == swa_pkg::ST_DIV, rem_q < divisor_q)
	`SWA_ASSERT_NEXT(a_full_sticky, filled_q, filled_q)
endmodule
`default_nettype wire
